// File: rtl/core/assert_macros.svh
// assertion macros shared by the compressor rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SKC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SKC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SKC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/skc_pkg.sv
// types, constants and constant functions of the compressor
// no dependencies
package skc_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_AMT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_EN   = 4'd7;

    localparam int DB_PER_LOG2 = 394566;
    localparam int LOG2_PER_DB = 2786635;
    localparam int DB_FLOOR    = -25600;
    localparam int RED_MAX     = 16384;

    typedef struct packed {
        logic signed [14:0] threshold_db;
        logic [15:0]        slope;
        logic [23:0]        attack_coef;
        logic [23:0]        release_coef;
        logic [12:0]        knee_db;
        logic [12:0]        makeup_db;
        logic [16:0]        side_amount;
        logic               side_enable;
    } skc_cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } skc_q_stat_t;

    function automatic logic [63:0] skc_isqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-(16-k)) in Q1.30, by repeated square roots
    function automatic logic [30:0] skc_base(input int k);
        logic [63:0] b;
        b = 64'h8000_0000;
        for (int i = 0; i < 16; i++)
        begin
            if (i <= 15 - k)
            begin
                b = skc_isqrt(b << 30);
            end
        end
        return b[30:0];
    endfunction

endpackage

// File: rtl/core/skc_if.sv
// beat interfaces of the compressor: sample input and result output
// no dependencies
interface skc_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          right_present;
    logic signed [SAMPLE_BITS-1:0] side_left;
    logic signed [SAMPLE_BITS-1:0] side_right;
    logic                          side_present;
    logic                          side_right_present;

    modport source (output valid, left_sample, right_sample, right_present, side_left,
                    side_right, side_present, side_right_present, input ready);
    modport sink (input valid, left_sample, right_sample, right_present, side_left,
                  side_right, side_present, side_right_present, output ready);
endinterface

interface skc_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [14:0]                   reduction_db;

    modport source (output valid, left_out, right_out, reduction_db, input ready);
    modport sink (input valid, left_out, right_out, reduction_db, output ready);
endinterface

// File: rtl/core/soft_knee_stereo_compressor.sv
// channel   | dir | payload
// in_ch     | in  | left/right sample, sidechain pair, presence flags
// out_ch    | out | left_out, right_out, reduction_db
// cfg_*     | in  | write enable, register index, write data
// the front takes one beat at a time and holds it until the queue has room
// the back takes one beat at a time through the normalise shifts, the
// log squaring loop, the knee divider and the gain mantissa products on one multiplier
// rst_n clears the envelope, the configuration and all handshake state
// a stalled output holds the back; the front keeps taking beats until the
// two-entry queue fills
module soft_knee_stereo_compressor
    import skc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    skc_in_if.sink                in_ch,
    skc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    skc_cfg_t                 cfg_reg;
    skc_q_stat_t              q_stat;
    logic                     push;
    logic                     pop;
    logic [3*SAMPLE_BITS-1:0] push_data;
    logic [3*SAMPLE_BITS-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold_db <= cfg_data[14:0];
                CFG_SLOPE:     cfg_reg.slope        <= cfg_data[15:0];
                CFG_ATTACK:    cfg_reg.attack_coef  <= cfg_data[23:0];
                CFG_RELEASE:   cfg_reg.release_coef <= cfg_data[23:0];
                CFG_KNEE:      cfg_reg.knee_db      <= cfg_data[12:0];
                CFG_MAKEUP:    cfg_reg.makeup_db    <= cfg_data[12:0];
                CFG_SIDE_AMT:  cfg_reg.side_amount  <= cfg_data[16:0];
                CFG_SIDE_EN:   cfg_reg.side_enable  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    skc_front #(.SB(SAMPLE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    skc_queue #(.WIDTH(3 * SAMPLE_BITS)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    skc_back #(.SB(SAMPLE_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

// File: rtl/core/skc_queue.sv
// two-entry queue between detector front and gain back
// depends on skc_pkg and assert_macros.svh
`include "assert_macros.svh"
module skc_queue
    import skc_pkg::*;
#(
    parameter int WIDTH = 72
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output skc_q_stat_t      stat
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == 2'd0);
    assign stat.full  = (cnt_reg == 2'd2);

    `SKC_ASSERT_IMP(a_no_overrun, clk, rst_n, push, cnt_reg != 2'd2)
    `SKC_ASSERT_IMP(a_no_underrun, clk, rst_n, pop, cnt_reg != 2'd0)

endmodule

// File: rtl/core/skc_front.sv
// detector front: takes sample beats, blends sidechain, updates envelope
// depends on skc_pkg and skc_if
module skc_front
    import skc_pkg::*;
#(
    parameter int SB = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    skc_in_if.sink          in_ch,
    input  skc_cfg_t        cfg,
    input  skc_q_stat_t     q_stat,
    output logic            push,
    output logic [3*SB-1:0] push_data
);

    localparam int EW = SB - 1;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_B1   = 3'd1;
    localparam logic [2:0] F_B2   = 3'd2;
    localparam logic [2:0] F_B3   = 3'd3;
    localparam logic [2:0] F_ENV  = 3'd4;
    localparam logic [2:0] F_UPD  = 3'd5;
    localparam logic [2:0] F_PUSH = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [EW-1:0] det_reg;
    logic [EW-1:0] sd_reg;
    logic [EW-1:0] env_reg;
    logic          rise_reg;
    logic [55:0]   acc_reg;
    logic [55:0]   prod_reg;
    logic [SB-1:0] ls_reg;
    logic [SB-1:0] rs_reg;
    logic          rp_reg;

    logic [31:0]   fa;
    logic [23:0]   fb;
    logic [16:0]   amt;
    logic [EW-1:0] ml;
    logic [EW-1:0] mr;
    logic [EW-1:0] sl;
    logic [EW-1:0] sr;
    logic [EW-1:0] rnd;
    logic          accept;

    function automatic logic [EW-1:0] mag_sat(input logic [SB-1:0] v);
        logic [SB-1:0] a;
        a = v[SB-1] ? ({SB{1'b0}} - v) : v;
        return a[SB-1] ? {EW{1'b1}} : a[EW-1:0];
    endfunction

    assign ml  = mag_sat(in_ch.left_sample);
    assign mr  = in_ch.right_present ? mag_sat(in_ch.right_sample) : ml;
    assign sl  = mag_sat(in_ch.side_left);
    assign sr  = in_ch.side_right_present ? mag_sat(in_ch.side_right) : sl;
    assign amt = (cfg.side_amount[16] && (|cfg.side_amount[15:0])) ? 17'h10000
                                                                     : cfg.side_amount;
    assign rnd = EW'((prod_reg + 56'h80_0000) >> 24);

    assign in_ch.ready = (state_reg == F_IDLE);
    assign accept      = in_ch.valid && (state_reg == F_IDLE);
    assign push        = (state_reg == F_PUSH) && !q_stat.full;
    assign push_data   = {rp_reg, rs_reg, ls_reg, env_reg};

    always_comb
    begin
        fa = '0;
        fb = '0;
        case (state_reg)
            F_B1:
            begin
                fa = 32'(det_reg);
                fb = 24'(17'h10000 - amt);
            end
            F_B2:
            begin
                fa = 32'(sd_reg);
                fb = 24'(amt);
            end
            F_ENV:
            begin
                fa = (det_reg > env_reg) ? 32'(det_reg - env_reg) : 32'(env_reg - det_reg);
                fb = (det_reg > env_reg) ? cfg.attack_coef : cfg.release_coef;
            end
            default:
            begin
                fa = '0;
                fb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (cfg.side_enable && in_ch.side_present) ? F_B1 : F_ENV;
                end
            end
            F_B1:   state_next = F_B2;
            F_B2:   state_next = F_B3;
            F_B3:   state_next = F_ENV;
            F_ENV:  state_next = F_UPD;
            F_UPD:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            env_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_UPD)
            begin
                env_reg <= rise_reg ? (det_reg - rnd) : (det_reg + rnd);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 56'(fa) * 56'(fb);
        if (accept)
        begin
            det_reg <= (ml > mr) ? ml : mr;
            sd_reg  <= (sl > sr) ? sl : sr;
            ls_reg  <= in_ch.left_sample;
            rs_reg  <= in_ch.right_sample;
            rp_reg  <= in_ch.right_present;
        end
        if (state_reg == F_B2)
        begin
            acc_reg <= prod_reg;
        end
        if (state_reg == F_B3)
        begin
            det_reg <= EW'((acc_reg + prod_reg + 56'd32768) >> 16);
        end
        if (state_reg == F_ENV)
        begin
            rise_reg <= (det_reg > env_reg);
        end
    end

endmodule

// File: rtl/core/skc_back.sv
// gain back: envelope to dB, knee, makeup, gain and output scaling
// depends on skc_pkg, skc_if and assert_macros.svh
`include "assert_macros.svh"
module skc_back
    import skc_pkg::*;
#(
    parameter int SB = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  skc_cfg_t        cfg,
    input  skc_q_stat_t     q_stat,
    input  logic [3*SB-1:0] pop_data,
    output logic            pop,
    skc_out_if.source       out_ch
);

    localparam int EW = SB - 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_NORM   = 5'd1;
    localparam logic [4:0] S_SQ     = 5'd2;
    localparam logic [4:0] S_SQW    = 5'd3;
    localparam logic [4:0] S_DB1    = 5'd4;
    localparam logic [4:0] S_DB2    = 5'd5;
    localparam logic [4:0] S_OVER   = 5'd6;
    localparam logic [4:0] S_LIN    = 5'd7;
    localparam logic [4:0] S_Q1     = 5'd8;
    localparam logic [4:0] S_Q2     = 5'd9;
    localparam logic [4:0] S_DIV    = 5'd10;
    localparam logic [4:0] S_DIVEND = 5'd11;
    localparam logic [4:0] S_EXP    = 5'd12;
    localparam logic [4:0] S_EXP2   = 5'd13;
    localparam logic [4:0] S_GM     = 5'd14;
    localparam logic [4:0] S_GMW    = 5'd15;
    localparam logic [4:0] S_OUTL   = 5'd16;
    localparam logic [4:0] S_OUTL2  = 5'd17;
    localparam logic [4:0] S_OUTR2  = 5'd18;
    localparam logic [4:0] S_SEND   = 5'd19;

    logic [4:0]               state_reg;
    logic [4:0]               state_next;
    logic [SB-1:0]            ls_reg;
    logic [SB-1:0]            rs_reg;
    logic                     rp_reg;
    logic [31:0]              m_reg;
    logic signed [5:0]        lgi_reg;
    logic [15:0]              lgf_reg;
    logic [3:0]               k_reg;
    logic [4:0]               cnt_reg;
    logic signed [15:0]       edb_reg;
    logic [14:0]              red_reg;
    logic [27:0]              div_q_reg;
    logic [12:0]              div_r_reg;
    logic signed [5:0]        ie_reg;
    logic [15:0]              f_reg;
    logic [30:0]              mant_reg;
    logic signed [SB-1:0]     left_reg;
    logic signed [SB-1:0]     right_reg;
    logic signed [65:0]       prod_reg;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic [63:0]              pu;
    logic [EW-1:0]            env_in;
    logic signed [21:0]       lg;
    logic signed [65:0]       dbs;
    logic signed [65:0]       es;
    logic signed [17:0]       over_v;
    logic signed [18:0]       two_over;
    logic signed [18:0]       kn_s;
    logic signed [18:0]       t2;
    logic                     lin;
    logic                     quad;
    logic [47:0]              red_lin;
    logic [47:0]              num;
    logic [13:0]              rsh;
    logic signed [15:0]       gdb;
    logic [30:0]              base_tab [16];
    logic [SB-1:0]            mag_l;
    logic [SB-1:0]            mag_r;
    logic [6:0]               sh;
    logic [64:0]              sc_r;
    logic                     sc_neg;
    logic [SB-1:0]            sc_out;

    for (genvar g = 0; g < 16; g++)
    begin : g_base
        assign base_tab[g] = skc_base(g);
    end

    assign pu       = prod_reg[63:0];
    assign env_in   = pop_data[EW-1:0];
    assign lg       = {lgi_reg, lgf_reg};
    assign dbs      = (prod_reg + 66'sd8388608) >>> 24;
    assign es       = (prod_reg + 66'sd32768) >>> 16;
    assign over_v   = 18'(edb_reg) - 18'(cfg.threshold_db);
    assign two_over = {over_v, 1'b0};
    assign kn_s     = {6'b0, cfg.knee_db};
    assign t2       = two_over + kn_s;
    assign lin      = (cfg.knee_db == '0) ? (over_v > 18'sd0) : (two_over > kn_s);
    assign quad     = (cfg.knee_db != '0) && (two_over > -kn_s);
    assign red_lin  = (pu[47:0] + 48'd32768) >> 16;
    assign num      = pu[47:0] + (48'(cfg.knee_db) << 18);
    assign rsh      = {div_r_reg, div_q_reg[27]};
    assign gdb      = 16'(cfg.makeup_db) - 16'(red_reg);
    assign mag_l    = ls_reg[SB-1] ? ({SB{1'b0}} - ls_reg) : ls_reg;
    assign mag_r    = rs_reg[SB-1] ? ({SB{1'b0}} - rs_reg) : rs_reg;

    // round half away from zero on the magnitude, then saturate
    assign sh     = 7'(7'sd30 - 7'(ie_reg));
    assign sc_r   = (65'(pu) + (65'(1) << (sh - 7'd1))) >> sh;
    assign sc_neg = (state_reg == S_OUTL2) ? ls_reg[SB-1] : rs_reg[SB-1];
    always_comb
    begin
        if (sc_neg)
        begin
            sc_out = (sc_r > (65'(1) << (SB - 1))) ? {1'b1, {EW{1'b0}}}
                                                    : ({SB{1'b0}} - sc_r[SB-1:0]);
        end
        else
        begin
            sc_out = (sc_r > 65'({EW{1'b1}})) ? {1'b0, {EW{1'b1}}} : sc_r[SB-1:0];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            S_DB1:
            begin
                mul_a = 33'(lg);
                mul_b = 33'(DB_PER_LOG2);
            end
            S_OVER:
            begin
                if (lin)
                begin
                    mul_a = 33'(over_v);
                    mul_b = {17'b0, cfg.slope};
                end
                else
                begin
                    mul_a = 33'(t2);
                    mul_b = 33'(t2);
                end
            end
            S_Q1:
            begin
                mul_a = {3'b0, pu[29:0]};
                mul_b = {17'b0, cfg.slope};
            end
            S_EXP:
            begin
                mul_a = 33'(gdb);
                mul_b = 33'(LOG2_PER_DB);
            end
            S_GM:
            begin
                mul_a = {2'b0, mant_reg};
                mul_b = {2'b0, base_tab[k_reg]};
            end
            S_OUTL:
            begin
                mul_a = 33'(mag_l);
                mul_b = {2'b0, mant_reg};
            end
            S_OUTL2:
            begin
                mul_a = 33'(mag_r);
                mul_b = {2'b0, mant_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pop           = (state_reg == S_IDLE) && !q_stat.empty;
    assign out_ch.valid  = (state_reg == S_SEND);
    assign out_ch.left_out     = left_reg;
    assign out_ch.right_out    = right_reg;
    assign out_ch.reduction_db = red_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = (env_in == '0) ? S_OVER : S_NORM;
                end
            end
            S_NORM:   state_next = m_reg[30] ? S_SQ : S_NORM;
            S_SQ:     state_next = S_SQW;
            S_SQW:    state_next = (k_reg == 4'd15) ? S_DB1 : S_SQ;
            S_DB1:    state_next = S_DB2;
            S_DB2:    state_next = S_OVER;
            S_OVER:   state_next = lin ? S_LIN : (quad ? S_Q1 : S_EXP);
            S_LIN:    state_next = S_EXP;
            S_Q1:     state_next = S_Q2;
            S_Q2:     state_next = S_DIV;
            S_DIV:    state_next = (cnt_reg == 5'd27) ? S_DIVEND : S_DIV;
            S_DIVEND: state_next = S_EXP;
            S_EXP:    state_next = S_EXP2;
            S_EXP2:   state_next = S_GM;
            S_GM:
            begin
                if (f_reg[k_reg])
                begin
                    state_next = S_GMW;
                end
                else if (k_reg == 4'd0)
                begin
                    state_next = S_OUTL;
                end
            end
            S_GMW:    state_next = (k_reg == 4'd0) ? S_OUTL : S_GM;
            S_OUTL:   state_next = S_OUTL2;
            S_OUTL2:  state_next = rp_reg ? S_OUTR2 : S_SEND;
            S_OUTR2:  state_next = S_SEND;
            S_SEND:   state_next = out_ch.ready ? S_IDLE : S_SEND;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                ls_reg  <= pop_data[2*SB-2:SB-1];
                rs_reg  <= pop_data[3*SB-2:2*SB-1];
                rp_reg  <= pop_data[3*SB-1];
                m_reg   <= 32'(env_in) << (32 - SB);
                lgi_reg <= '0;
                lgf_reg <= '0;
                k_reg   <= '0;
                edb_reg <= 16'(DB_FLOOR);
            end
            S_NORM:
            begin
                if (!m_reg[30])
                begin
                    m_reg   <= m_reg << 1;
                    lgi_reg <= lgi_reg - 6'sd1;
                end
            end
            S_SQW:
            begin
                if (pu[61])
                begin
                    m_reg          <= {1'b0, pu[61:31]};
                    lgf_reg[~k_reg] <= 1'b1;
                end
                else
                begin
                    m_reg <= pu[61:30];
                end
                k_reg <= k_reg + 4'd1;
            end
            S_DB2:
            begin
                edb_reg <= (dbs < 66'sd0 - 66'sd25600) ? 16'(DB_FLOOR) : 16'(dbs);
            end
            S_OVER:
            begin
                red_reg <= '0;
            end
            S_LIN:
            begin
                red_reg <= (red_lin > 48'(RED_MAX)) ? 15'(RED_MAX) : red_lin[14:0];
            end
            S_Q2:
            begin
                div_q_reg <= num[46:19];
                div_r_reg <= '0;
                cnt_reg   <= '0;
            end
            S_DIV:
            begin
                if (rsh >= {1'b0, cfg.knee_db})
                begin
                    div_r_reg <= 13'(rsh - {1'b0, cfg.knee_db});
                    div_q_reg <= {div_q_reg[26:0], 1'b1};
                end
                else
                begin
                    div_r_reg <= rsh[12:0];
                    div_q_reg <= {div_q_reg[26:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            S_DIVEND:
            begin
                red_reg <= (div_q_reg > 28'(RED_MAX)) ? 15'(RED_MAX) : div_q_reg[14:0];
            end
            S_EXP2:
            begin
                ie_reg   <= es[21:16];
                f_reg    <= es[15:0];
                mant_reg <= 31'h4000_0000;
                k_reg    <= 4'd15;
            end
            S_GM:
            begin
                if (!f_reg[k_reg] && (k_reg != 4'd0))
                begin
                    k_reg <= k_reg - 4'd1;
                end
            end
            S_GMW:
            begin
                mant_reg <= 31'((pu + 64'h2000_0000) >> 30);
                if (k_reg != 4'd0)
                begin
                    k_reg <= k_reg - 4'd1;
                end
            end
            S_OUTL2:
            begin
                left_reg  <= sc_out;
                right_reg <= '0;
            end
            S_OUTR2:
            begin
                right_reg <= sc_out;
            end
            default:
            begin
            end
        endcase
    end

    `SKC_ASSERT_IMP(a_red_max, clk, rst_n, out_ch.valid, out_ch.reduction_db <= 15'(RED_MAX))
    `SKC_ASSERT_NXT(a_pop_busy, clk, rst_n, pop, state_reg != S_IDLE)

endmodule
